// ===== hw/rtl/ptu_pkg.sv =====
package ptu_pkg;

	localparam int unsigned LaneW     = 16;
	localparam int unsigned PosW      = 32;
	localparam int unsigned LifeW     = 24;
	localparam int unsigned CfgW      = 64;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned MulAW     = 34;
	localparam int unsigned MulBW     = 17;
	localparam int unsigned MulPW     = MulAW + MulBW;
	localparam int unsigned DivNumW   = 32;
	localparam int unsigned DivSteps  = 16;
	localparam int unsigned DivCntW   = $clog2(DivSteps + 1);
	localparam int unsigned DivQW     = DivSteps + 1;
	localparam int unsigned NumAxes   = 3;
	localparam int unsigned NumChans  = 4;
	localparam int unsigned OutDataW  = NumAxes * PosW + NumChans * LaneW;

	localparam logic [1:0] LastAxis = 2'(NumAxes - 1);
	localparam logic [1:0] LastChan = 2'(NumChans - 1);

	localparam logic signed [LaneW-1:0] MaxGravityRst  = 16'sd32767;
	localparam logic [LaneW-1:0]        SpeedRst       = 16'd256;
	localparam logic [LifeW-1:0]        MaxLifetimeRst = 24'd65536;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GRAVITY_FORCE = 3'd0,
		REG_DIRECTION     = 3'd1,
		REG_MAX_GRAVITY   = 3'd2,
		REG_SPEED         = 3'd3,
		REG_MAX_LIFETIME  = 3'd4,
		REG_COLOR_DELTA   = 3'd5,
		REG_START_COLOR   = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PULL_MUL,
		ST_PULL_ACC,
		ST_MOV_MUL1,
		ST_MOV_MUL2,
		ST_MOV_ACC,
		ST_COL_MUL,
		ST_COL_DIV,
		ST_COL_WAIT,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/ptu_mul.sv =====
module ptu_mul (
	input  logic                                  clk,
	input  logic signed [ptu_pkg::MulAW-1:0]      a,
	input  logic signed [ptu_pkg::MulBW-1:0]      b,
	output logic signed [ptu_pkg::MulPW-1:0]      p_q
);

	always_ff @(posedge clk) begin
		p_q <= ptu_pkg::MulPW'(a) * ptu_pkg::MulPW'(b);
	end

endmodule

// ===== hw/rtl/ptu_div.sv =====
module ptu_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [ptu_pkg::DivNumW-1:0]    num,
	input  logic        [ptu_pkg::LifeW-1:0]      den,
	output logic                                  done_q,
	output logic signed [ptu_pkg::DivQW-1:0]      quot
);

	logic                              busy_q;
	logic [ptu_pkg::DivCntW-1:0]       cnt_q;
	logic [ptu_pkg::LifeW-1:0]         rem_q;
	logic [ptu_pkg::DivSteps-1:0]      sh_q;
	logic                              neg_q;
	logic                              ovf_q;
	logic [ptu_pkg::DivNumW-1:0]       mag;
	logic [ptu_pkg::LifeW-1:0]         mag_hi;
	logic [ptu_pkg::LifeW:0]           trial;
	logic                              ge;
	logic [ptu_pkg::DivQW-1:0]         qmag;

	assign mag    = num[ptu_pkg::DivNumW-1] ? ptu_pkg::DivNumW'(-num) : ptu_pkg::DivNumW'(num);
	assign mag_hi = ptu_pkg::LifeW'(mag[ptu_pkg::DivNumW-1:ptu_pkg::DivSteps]);
	assign trial  = {rem_q, sh_q[ptu_pkg::DivSteps-1]};
	assign ge     = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == ptu_pkg::DivCntW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ptu_pkg::DivCntW'(ptu_pkg::DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ptu_pkg::DivCntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[ptu_pkg::DivNumW-1];
			ovf_q <= mag_hi >= den;
			rem_q <= mag_hi;
			sh_q  <= mag[ptu_pkg::DivSteps-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? ptu_pkg::LifeW'(trial - {1'b0, den}) : trial[ptu_pkg::LifeW-1:0];
			sh_q  <= {sh_q[ptu_pkg::DivSteps-2:0], ge};
		end
	end

	// A negative quotient rounds toward minus infinity, so a nonzero remainder bumps it.
	// A quotient too large for 16 bits is clamped, since the color saturates either way.
	assign qmag = ovf_q ? {1'b0, {ptu_pkg::DivSteps{1'b1}}}
		: {1'b0, sh_q} + ptu_pkg::DivQW'(neg_q && (rem_q != '0));
	assign quot = neg_q ? -$signed(qmag) : $signed(qmag);

endmodule

// ===== hw/rtl/particle_tick_update_core.sv =====
// Advances one particle by one time step per input beat and returns one result beat with
// its position, color and dead flag. A spawn beat, or a beat for a particle that has reached
// its lifetime, goes straight to the done state after acceptance. A live particle runs
// its steps in sequence: a shared multiplier runs 13 products one after another, and a
// 16-step divider runs once for each of the four color channels and dominates the run time.
// No new beat is accepted while one is in work. The next beat is accepted once the result
// has moved into the output register, even while that result still waits to be taken; a
// full output register holds the block until it drains.
module particle_tick_update_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [15:0]                            s_axis_tdata,  // dt
	input  logic                                   s_axis_tuser,  // spawn
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// pos_x, pos_y, pos_z, color_r, color_g, color_b, color_a
	output logic [ptu_pkg::OutDataW-1:0]           m_axis_tdata,
	output logic                                   m_axis_tuser,  // dead
	input  logic                                   cfg_we,
	input  logic [ptu_pkg::CfgIdxW-1:0]            cfg_index,
	input  logic [ptu_pkg::CfgW-1:0]               cfg_data
);

	localparam int unsigned LW = ptu_pkg::LaneW;
	localparam int unsigned PW = ptu_pkg::PosW;

	logic [3*LW-1:0]                 gravity_q;
	logic [3*LW-1:0]                 direction_q;
	logic signed [LW-1:0]            max_gravity_q;
	logic [LW-1:0]                   speed_q;
	logic [ptu_pkg::LifeW-1:0]       max_life_q;
	logic [4*LW-1:0]                 color_delta_q;
	logic [4*LW-1:0]                 start_color_q;

	logic [ptu_pkg::LifeW-1:0]       elapsed_q;
	logic signed [LW-1:0]            pull_q [ptu_pkg::NumAxes];
	logic signed [PW-1:0]            pos_q [ptu_pkg::NumAxes];
	logic signed [LW-1:0]            color_q [ptu_pkg::NumChans];
	logic                            expired_q;
	logic [LW-1:0]                   dt_q;
	logic [1:0]                      idx_q;

	ptu_pkg::state_t                 state_q, state_d;
	logic                            s_accept;
	logic                            out_load;
	logic                            m_tvalid_q;
	logic [ptu_pkg::OutDataW-1:0]    m_tdata_q;
	logic                            m_tuser_q;

	logic [ptu_pkg::LifeW:0]         life_sum;
	logic [ptu_pkg::LifeW-1:0]       life_sat;
	logic                            live;

	logic signed [ptu_pkg::MulAW-1:0] mul_a;
	logic signed [ptu_pkg::MulBW-1:0] mul_b;
	logic signed [ptu_pkg::MulPW-1:0] mul_p;
	logic                            div_start;
	logic                            div_done;
	logic signed [ptu_pkg::DivQW-1:0] div_quot;

	logic [5:0]                      lane_lo;
	logic signed [LW-1:0]            grav_lane;
	logic signed [LW-1:0]            dir_lane;
	logic signed [LW-1:0]            cd_lane;
	logic signed [LW:0]              pull_sum;
	logic signed [LW-1:0]            pull_new;
	logic signed [LW:0]              dir_sum;
	logic signed [PW+1:0]            pos_sum;
	logic signed [PW-1:0]            pos_new;
	logic signed [LW+1:0]            col_sum;
	logic signed [LW-1:0]            col_new;

	function automatic logic signed [LW:0] sig32k();
		sig32k = (LW + 1)'(1) <<< (LW - 1);
	endfunction

	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	assign lane_lo   = {idx_q, 4'b0000};
	assign grav_lane = $signed(gravity_q[lane_lo +: LW]);
	assign dir_lane  = $signed(direction_q[lane_lo +: LW]);
	assign cd_lane   = $signed(color_delta_q[lane_lo +: LW]);

	assign life_sum = {1'b0, elapsed_q} + (ptu_pkg::LifeW + 1)'(s_axis_tdata);
	assign life_sat = life_sum[ptu_pkg::LifeW] ? '1 : life_sum[ptu_pkg::LifeW-1:0];
	assign live     = life_sat < max_life_q;

	// Pull: the product's upper half is the floored gravity increment.
	always_comb begin
		pull_sum = (LW + 1)'(pull_q[idx_q]) + (LW + 1)'($signed(mul_p[2*LW-1:LW]));
		if (pull_sum > (LW + 1)'(max_gravity_q)) begin
			pull_new = max_gravity_q;
		end else if (pull_sum < -(LW + 1)'(sig32k())) begin
			pull_new = {1'b1, {(LW - 1){1'b0}}};
		end else begin
			pull_new = pull_sum[LW-1:0];
		end
	end

	assign dir_sum = (LW + 1)'(dir_lane) + (LW + 1)'(pull_q[idx_q]);

	always_comb begin
		pos_sum = (PW + 2)'(pos_q[idx_q]) + (PW + 2)'($signed(mul_p[PW+LW:LW]));
		if (pos_sum > (PW + 2)'($signed({1'b0, {(PW - 1){1'b1}}}))) begin
			pos_new = {1'b0, {(PW - 1){1'b1}}};
		end else if (pos_sum < (PW + 2)'($signed({1'b1, {(PW - 1){1'b0}}}))) begin
			pos_new = {1'b1, {(PW - 1){1'b0}}};
		end else begin
			pos_new = pos_sum[PW-1:0];
		end
	end

	always_comb begin
		col_sum = (LW + 2)'(color_q[idx_q]) + (LW + 2)'(div_quot);
		if (col_sum > (LW + 2)'($signed({1'b0, {(LW - 1){1'b1}}}))) begin
			col_new = {1'b0, {(LW - 1){1'b1}}};
		end else if (col_sum < (LW + 2)'($signed({1'b1, {(LW - 1){1'b0}}}))) begin
			col_new = {1'b1, {(LW - 1){1'b0}}};
		end else begin
			col_new = col_sum[LW-1:0];
		end
	end

	ptu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	ptu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_p[ptu_pkg::DivNumW-1:0]),
		.den    (max_life_q),
		.done_q (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptu_pkg::ST_IDLE: begin
				if (s_accept) begin
					state_d = (s_axis_tuser || !live) ? ptu_pkg::ST_DONE : ptu_pkg::ST_PULL_MUL;
				end
			end
			ptu_pkg::ST_PULL_MUL: state_d = ptu_pkg::ST_PULL_ACC;
			ptu_pkg::ST_PULL_ACC: begin
				state_d = (idx_q == ptu_pkg::LastAxis) ? ptu_pkg::ST_MOV_MUL1
					: ptu_pkg::ST_PULL_MUL;
			end
			ptu_pkg::ST_MOV_MUL1: state_d = ptu_pkg::ST_MOV_MUL2;
			ptu_pkg::ST_MOV_MUL2: state_d = ptu_pkg::ST_MOV_ACC;
			ptu_pkg::ST_MOV_ACC: begin
				state_d = (idx_q == ptu_pkg::LastAxis) ? ptu_pkg::ST_COL_MUL
					: ptu_pkg::ST_MOV_MUL1;
			end
			ptu_pkg::ST_COL_MUL: state_d = ptu_pkg::ST_COL_DIV;
			ptu_pkg::ST_COL_DIV: state_d = ptu_pkg::ST_COL_WAIT;
			ptu_pkg::ST_COL_WAIT: begin
				if (div_done) begin
					state_d = (idx_q == ptu_pkg::LastChan) ? ptu_pkg::ST_DONE
						: ptu_pkg::ST_COL_MUL;
				end
			end
			ptu_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = ptu_pkg::ST_IDLE;
				end
			end
			default: state_d = ptu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		div_start     = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			ptu_pkg::ST_IDLE: s_axis_tready = 1'b1;
			ptu_pkg::ST_PULL_MUL: begin
				mul_a = ptu_pkg::MulAW'(grav_lane);
				mul_b = $signed({1'b0, dt_q});
			end
			ptu_pkg::ST_MOV_MUL1: begin
				mul_a = ptu_pkg::MulAW'(dir_sum);
				mul_b = $signed({1'b0, speed_q});
			end
			ptu_pkg::ST_MOV_MUL2: begin
				mul_a = mul_p[ptu_pkg::MulAW-1:0];
				mul_b = $signed({1'b0, dt_q});
			end
			ptu_pkg::ST_COL_MUL: begin
				mul_a = ptu_pkg::MulAW'(cd_lane);
				mul_b = $signed({1'b0, dt_q});
			end
			ptu_pkg::ST_COL_DIV: div_start = 1'b1;
			ptu_pkg::ST_DONE: out_load = !m_tvalid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ptu_pkg::ST_IDLE;
			idx_q         <= '0;
			m_tvalid_q    <= 1'b0;
			gravity_q     <= '0;
			direction_q   <= '0;
			max_gravity_q <= ptu_pkg::MaxGravityRst;
			speed_q       <= ptu_pkg::SpeedRst;
			max_life_q    <= ptu_pkg::MaxLifetimeRst;
			color_delta_q <= '0;
			start_color_q <= '0;
			elapsed_q     <= '0;
			expired_q     <= 1'b0;
			for (int i = 0; i < ptu_pkg::NumAxes; i++) begin
				pull_q[i] <= '0;
				pos_q[i]  <= '0;
			end
			for (int i = 0; i < ptu_pkg::NumChans; i++) begin
				color_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					ptu_pkg::REG_GRAVITY_FORCE: gravity_q     <= cfg_data[3*LW-1:0];
					ptu_pkg::REG_DIRECTION:     direction_q   <= cfg_data[3*LW-1:0];
					ptu_pkg::REG_MAX_GRAVITY:   max_gravity_q <= $signed(cfg_data[LW-1:0]);
					ptu_pkg::REG_SPEED:         speed_q       <= cfg_data[LW-1:0];
					ptu_pkg::REG_MAX_LIFETIME:  max_life_q    <= cfg_data[ptu_pkg::LifeW-1:0];
					ptu_pkg::REG_COLOR_DELTA:   color_delta_q <= cfg_data;
					ptu_pkg::REG_START_COLOR:   start_color_q <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				ptu_pkg::ST_IDLE: begin
					if (s_accept) begin
						if (s_axis_tuser) begin
							elapsed_q <= '0;
							expired_q <= 1'b0;
							for (int i = 0; i < ptu_pkg::NumAxes; i++) begin
								pull_q[i] <= '0;
								pos_q[i]  <= '0;
							end
							for (int i = 0; i < ptu_pkg::NumChans; i++) begin
								color_q[i] <= $signed(start_color_q[i*LW +: LW]);
							end
						end else begin
							elapsed_q <= life_sat;
							if (!live) begin
								expired_q <= 1'b1;
							end
						end
					end
				end
				ptu_pkg::ST_PULL_ACC: begin
					pull_q[idx_q] <= pull_new;
					idx_q         <= (idx_q == ptu_pkg::LastAxis) ? '0 : idx_q + 1'b1;
				end
				ptu_pkg::ST_MOV_ACC: begin
					pos_q[idx_q] <= pos_new;
					idx_q        <= (idx_q == ptu_pkg::LastAxis) ? '0 : idx_q + 1'b1;
				end
				ptu_pkg::ST_COL_WAIT: begin
					if (div_done) begin
						color_q[idx_q] <= col_new;
						idx_q          <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			dt_q <= s_axis_tdata;
		end
		if (out_load) begin
			m_tdata_q <= {color_q[3], color_q[2], color_q[1], color_q[0],
				pos_q[2], pos_q[1], pos_q[0]};
			m_tuser_q <= expired_q;
		end
	end

`ifndef SYNTHESIS
	a_spawn_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_axis_tuser) |=> (state_q == ptu_pkg::ST_DONE && !expired_q))
		else $error("spawn beat did not clear the particle");

	a_expired_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !s_axis_tuser && !live) |=> (state_q == ptu_pkg::ST_DONE && expired_q))
		else $error("expired particle was advanced");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ptu_pkg::ST_COL_WAIT))
		else $error("divider finished outside the color wait");
`endif

endmodule
